@@ rtl/c_subset_lexer_unit_defines.svh @@
// Assertion macros shared by the lexer RTL.
`ifndef C_SUBSET_LEXER_UNIT_DEFINES_SVH
`define C_SUBSET_LEXER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

`define CSL_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("csl assertion failed");

`define CSL_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("csl assertion failed");

`else

`define CSL_ASSERT_IMP(label, ante, cons)

`define CSL_ASSERT_NXT(label, ante, cons)

`endif

`endif

@@ rtl/csl_pkg.sv @@
package csl_pkg;

    localparam int DEF_LENGTH_BITS = 8;
    localparam int DEF_COUNT_BITS  = 16;
    localparam int QDEPTH          = 4;

    localparam int KIND_W  = 4;
    localparam int LEN_W   = 8;
    localparam int KWI_W   = 2;
    localparam int TOTAL_W = 16;

    localparam logic [KIND_W-1:0] K_KEYWORD = 4'd0;
    localparam logic [KIND_W-1:0] K_IDENT   = 4'd1;
    localparam logic [KIND_W-1:0] K_INT     = 4'd2;
    localparam logic [KIND_W-1:0] K_FLOAT   = 4'd3;
    localparam logic [KIND_W-1:0] K_PLUS    = 4'd4;
    localparam logic [KIND_W-1:0] K_MINUS   = 4'd5;
    localparam logic [KIND_W-1:0] K_ASSIGN  = 4'd6;
    localparam logic [KIND_W-1:0] K_EQUAL   = 4'd7;
    localparam logic [KIND_W-1:0] K_STAR    = 4'd8;
    localparam logic [KIND_W-1:0] K_TOTAL   = 4'd9;

    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef struct packed {
        logic [7:0] ch;
        logic       end_of_text;
    } csl_src_t;

    typedef struct packed {
        logic [KIND_W-1:0]  token_kind;
        logic [LEN_W-1:0]   token_length;
        logic [KWI_W-1:0]   keyword_index;
        logic [TOTAL_W-1:0] token_total;
        logic               last_of_run;
    } csl_res_t;

    typedef struct packed {
        csl_res_t res0;
        csl_res_t res1;
    } csl_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } csl_qstat_t;

    function automatic logic [2:0] kw_len(input logic [1:0] k);
        logic [2:0] len;
        unique case (k)
            2'd0: len = 3'd3;
            2'd1: len = 3'd2;
            2'd2: len = 3'd4;
            2'd3: len = 3'd5;
            default: len = 3'd0;
        endcase
        return len;
    endfunction

    function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] pos);
        logic [7:0] c;
        unique case ({k, pos})
            {2'd0, 3'd0}: c = 8'h69;
            {2'd0, 3'd1}: c = 8'h6E;
            {2'd0, 3'd2}: c = 8'h74;
            {2'd1, 3'd0}: c = 8'h69;
            {2'd1, 3'd1}: c = 8'h66;
            {2'd2, 3'd0}: c = 8'h65;
            {2'd2, 3'd1}: c = 8'h6C;
            {2'd2, 3'd2}: c = 8'h73;
            {2'd2, 3'd3}: c = 8'h65;
            {2'd3, 3'd0}: c = 8'h77;
            {2'd3, 3'd1}: c = 8'h68;
            {2'd3, 3'd2}: c = 8'h69;
            {2'd3, 3'd3}: c = 8'h6C;
            {2'd3, 3'd4}: c = 8'h65;
            default:      c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

@@ rtl/c_subset_lexer_unit.sv @@
// Streaming lexer for a small C subset: one source byte is taken per cycle
// and token records come out in source order, with a total record after each
// end-of-text item. A byte that ends a pending token can give two records; the
// output register drains one record per cycle while tok_stall is low, so such
// bytes fill the four-entry queue between the scanner and the output and the
// byte input stalls only once that queue is full. The records of an accepted
// byte are registered in the queue and then loaded into the output register.
// No clearing pass is needed after reset.
module c_subset_lexer_unit #(
    parameter int LENGTH_BITS = csl_pkg::DEF_LENGTH_BITS,
    parameter int COUNT_BITS  = csl_pkg::DEF_COUNT_BITS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              src_valid,
    output logic              src_stall,
    input  csl_pkg::csl_src_t src_item,
    output logic              tok_valid,
    input  logic              tok_stall,
    output csl_pkg::csl_res_t tok_item
);
    import csl_pkg::*;

    csl_qstat_t qstat;
    csl_entry_t push_entry;
    csl_entry_t head;
    logic       push;
    logic       pop;

    csl_front #(
        .LENGTH_BITS(LENGTH_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_item  (src_item),
        .qstat     (qstat),
        .push      (push),
        .push_entry(push_entry)
    );

    csl_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_entry(push_entry),
        .pop       (pop),
        .qstat     (qstat),
        .head      (head)
    );

    csl_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .qstat    (qstat),
        .head     (head),
        .pop      (pop),
        .tok_valid(tok_valid),
        .tok_stall(tok_stall),
        .tok_item (tok_item)
    );

endmodule

@@ rtl/csl_queue.sv @@
`include "c_subset_lexer_unit_defines.svh"

module csl_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  csl_pkg::csl_entry_t push_entry,
    input  logic                pop,
    output csl_pkg::csl_qstat_t qstat,
    output csl_pkg::csl_entry_t head
);
    import csl_pkg::*;

    localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CNT_W = $clog2(QDEPTH + 1);

    csl_entry_t             entry_reg [QDEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]       count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

    assign qstat.full  = (count_reg == CNT_W'(QDEPTH));
    assign qstat.empty = (count_reg == '0);
    assign head        = entry_reg[rd_ptr_reg];

    `CSL_ASSERT_IMP(a_no_push_full, push, !qstat.full)
    `CSL_ASSERT_IMP(a_no_pop_empty, pop, !qstat.empty)
    `CSL_ASSERT_IMP(a_count_range, 1'b1, count_reg <= CNT_W'(QDEPTH))

endmodule

@@ rtl/csl_front.sv @@
`include "c_subset_lexer_unit_defines.svh"

module csl_front #(
    parameter int LENGTH_BITS = csl_pkg::DEF_LENGTH_BITS,
    parameter int COUNT_BITS  = csl_pkg::DEF_COUNT_BITS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                src_valid,
    output logic                src_stall,
    input  csl_pkg::csl_src_t   src_item,
    input  csl_pkg::csl_qstat_t qstat,
    output logic                push,
    output csl_pkg::csl_entry_t push_entry
);
    import csl_pkg::*;

    localparam logic [2:0] M_IDLE   = 3'd0;
    localparam logic [2:0] M_SLASH  = 3'd1;
    localparam logic [2:0] M_LINE   = 3'd2;
    localparam logic [2:0] M_BLOCK  = 3'd3;
    localparam logic [2:0] M_BSTAR  = 3'd4;
    localparam logic [2:0] M_IDENT  = 3'd5;
    localparam logic [2:0] M_NUMBER = 3'd6;
    localparam logic [2:0] M_ASSIGN = 3'd7;

    localparam logic [LENGTH_BITS-1:0] RUN_MAX   = '1;
    localparam logic [COUNT_BITS-1:0]  TALLY_MAX = '1;

    logic [2:0]             mode_reg, mode_next;
    logic [LENGTH_BITS-1:0] run_reg, run_next;
    logic [3:0]             cand_reg, cand_next;
    logic                   float_reg, float_next;
    logic [COUNT_BITS-1:0]  tally_reg, tally_next;

    logic                   accept;
    logic [7:0]             ch;
    logic                   eot;
    logic                   is_space, is_alpha, is_digit, is_word;
    logic [LENGTH_BITS-1:0] run_ext;
    logic [3:0]             cand_first, cand_cont;

    logic                   f_valid;
    logic                   f_used;
    csl_res_t               f_res;
    logic [2:0]             idl_mode;
    logic                   idl_valid;
    logic [KIND_W-1:0]      idl_kind;
    logic [LENGTH_BITS-1:0] idl_run;
    logic [3:0]             idl_cand;
    logic                   idl_float;

    logic                   use_fi;
    logic                   s_valid;
    csl_res_t               s_res;
    logic [1:0]             tok_cnt;
    logic [COUNT_BITS:0]    tally_sum;
    logic [COUNT_BITS-1:0]  tally_sat;

    assign ch        = src_item.ch;
    assign eot       = src_item.end_of_text;
    assign src_stall = qstat.full;
    assign accept    = src_valid && !qstat.full;

    assign is_space = (ch == CH_SPACE) || (ch >= 8'd9 && ch <= 8'd13);
    assign is_alpha = (ch >= 8'h41 && ch <= 8'h5A) || (ch >= 8'h61 && ch <= 8'h7A);
    assign is_digit = (ch >= 8'h30 && ch <= 8'h39);
    assign is_word  = is_alpha || is_digit || (ch == CH_UNDER);
    assign run_ext  = (run_reg == RUN_MAX) ? run_reg : run_reg + 1'b1;

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            cand_first[k] = (kw_char(2'(k), 3'd0) == ch);
            cand_cont[k]  = (run_reg < LENGTH_BITS'(kw_len(2'(k))))
                            && (kw_char(2'(k), run_reg[2:0]) == ch);
        end
    end

    // pending token flush
    always_comb
    begin
        f_valid             = 1'b0;
        f_res               = '0;
        f_res.token_length  = LEN_W'(run_reg);
        unique case (mode_reg)
            M_IDENT:
            begin
                f_valid          = 1'b1;
                f_res.token_kind = K_IDENT;
                for (int k = 0; k < 4; k++)
                begin
                    if (cand_reg[k] && run_reg == LENGTH_BITS'(kw_len(2'(k))))
                    begin
                        f_res.token_kind    = K_KEYWORD;
                        f_res.keyword_index = 2'(k);
                    end
                end
            end
            M_NUMBER:
            begin
                f_valid          = 1'b1;
                f_res.token_kind = float_reg ? K_FLOAT : K_INT;
            end
            M_ASSIGN:
            begin
                f_valid            = 1'b1;
                f_res.token_kind   = K_ASSIGN;
                f_res.token_length = LEN_W'(1);
            end
            default:
            begin
                f_valid = 1'b0;
            end
        endcase
    end

    // byte seen from the idle mode
    always_comb
    begin
        idl_mode  = M_IDLE;
        idl_valid = 1'b0;
        idl_kind  = K_PLUS;
        idl_run   = run_reg;
        idl_cand  = cand_reg;
        idl_float = float_reg;
        priority if (is_space)
        begin
            idl_mode = M_IDLE;
        end
        else if (ch == CH_SLASH)
        begin
            idl_mode = M_SLASH;
        end
        else if (is_alpha || ch == CH_UNDER)
        begin
            idl_mode = M_IDENT;
            idl_run  = LENGTH_BITS'(1);
            idl_cand = cand_first;
        end
        else if (is_digit)
        begin
            idl_mode  = M_NUMBER;
            idl_run   = LENGTH_BITS'(1);
            idl_float = 1'b0;
        end
        else if (ch == CH_PLUS)
        begin
            idl_valid = 1'b1;
            idl_kind  = K_PLUS;
        end
        else if (ch == CH_MINUS)
        begin
            idl_valid = 1'b1;
            idl_kind  = K_MINUS;
        end
        else if (ch == CH_STAR)
        begin
            idl_valid = 1'b1;
            idl_kind  = K_STAR;
        end
        else if (ch == CH_EQ)
        begin
            idl_mode = M_ASSIGN;
        end
    end

    always_comb
    begin
        mode_next  = mode_reg;
        run_next   = run_reg;
        cand_next  = cand_reg;
        float_next = float_reg;
        use_fi     = 1'b0;
        s_valid    = 1'b0;
        s_res      = '0;

        unique case (mode_reg)
            M_LINE:
            begin
                if (ch == CH_LF)
                begin
                    mode_next = M_IDLE;
                end
            end
            M_BLOCK:
            begin
                if (ch == CH_STAR)
                begin
                    mode_next = M_BSTAR;
                end
            end
            M_BSTAR:
            begin
                if (ch == CH_SLASH)
                begin
                    mode_next = M_IDLE;
                end
                else if (ch != CH_STAR)
                begin
                    mode_next = M_BLOCK;
                end
            end
            M_SLASH:
            begin
                if (ch == CH_SLASH)
                begin
                    mode_next = M_LINE;
                end
                else if (ch == CH_STAR)
                begin
                    mode_next = M_BLOCK;
                end
                else
                begin
                    use_fi = 1'b1;
                end
            end
            M_IDENT:
            begin
                if (is_word)
                begin
                    cand_next = cand_reg & cand_cont;
                    run_next  = run_ext;
                end
                else
                begin
                    use_fi = 1'b1;
                end
            end
            M_NUMBER:
            begin
                if (is_digit || ch == CH_DOT)
                begin
                    float_next = float_reg || (ch == CH_DOT);
                    run_next   = run_ext;
                end
                else
                begin
                    use_fi = 1'b1;
                end
            end
            M_ASSIGN:
            begin
                if (ch == CH_EQ)
                begin
                    s_valid            = 1'b1;
                    s_res.token_kind   = K_EQUAL;
                    s_res.token_length = LEN_W'(2);
                    mode_next          = M_IDLE;
                end
                else
                begin
                    use_fi = 1'b1;
                end
            end
            default:
            begin
                use_fi = 1'b1;
            end
        endcase

        if (use_fi)
        begin
            mode_next          = idl_mode;
            run_next           = idl_run;
            cand_next          = idl_cand;
            float_next         = idl_float;
            s_valid            = idl_valid;
            s_res              = '0;
            s_res.token_kind   = idl_kind;
            s_res.token_length = LEN_W'(1);
        end

        if (eot)
        begin
            s_valid = 1'b1;
        end

        tok_cnt = 2'(f_used) + 2'(s_valid && !eot);
        tally_sum  = {1'b0, tally_reg} + (COUNT_BITS + 1)'(tok_cnt);
        tally_sat  = (tally_sum > {1'b0, TALLY_MAX}) ? TALLY_MAX : tally_sum[COUNT_BITS-1:0];
        tally_next = tally_sat;

        if (eot)
        begin
            s_res             = '0;
            s_res.token_kind  = K_TOTAL;
            s_res.token_total = TOTAL_W'(tally_sat);
            mode_next         = M_IDLE;
            run_next          = '0;
            cand_next         = '0;
            float_next        = 1'b0;
            tally_next        = '0;
        end
    end

    assign f_used = f_valid && (eot || use_fi);

    always_comb
    begin
        push_entry                  = '0;
        push_entry.res0             = f_used ? f_res : s_res;
        push_entry.res0.last_of_run = !(f_used && s_valid);
        push_entry.res1             = s_res;
        push_entry.res1.last_of_run = 1'b1;
    end

    assign push = accept && (f_used || s_valid);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= M_IDLE;
            run_reg   <= '0;
            cand_reg  <= '0;
            float_reg <= 1'b0;
            tally_reg <= '0;
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            run_reg   <= run_next;
            cand_reg  <= cand_next;
            float_reg <= float_next;
            tally_reg <= tally_next;
        end
    end

    `CSL_ASSERT_NXT(a_eot_clears, accept && eot, mode_reg == M_IDLE && tally_reg == '0)
    `CSL_ASSERT_IMP(a_eot_pushes, accept && eot, push)

endmodule

@@ rtl/csl_back.sv @@
`include "c_subset_lexer_unit_defines.svh"

module csl_back (
    input  logic                clk,
    input  logic                rst_n,
    input  csl_pkg::csl_qstat_t qstat,
    input  csl_pkg::csl_entry_t head,
    output logic                pop,
    output logic                tok_valid,
    input  logic                tok_stall,
    output csl_pkg::csl_res_t   tok_item
);
    import csl_pkg::*;

    logic     valid_reg, valid_next;
    logic     sel_reg, sel_next;
    csl_res_t item_reg;
    csl_res_t pick;
    logic     load;

    assign pick = sel_reg ? head.res1 : head.res0;
    assign load = !qstat.empty && (!valid_reg || !tok_stall);
    assign pop  = load && pick.last_of_run;

    always_comb
    begin
        valid_next = valid_reg;
        sel_next   = sel_reg;
        if (load)
        begin
            valid_next = 1'b1;
            sel_next   = !pick.last_of_run;
        end
        else if (!tok_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            sel_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            sel_reg   <= sel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= pick;
        end
    end

    assign tok_valid = valid_reg;
    assign tok_item  = item_reg;

    `CSL_ASSERT_IMP(a_sel_has_head, sel_reg, !qstat.empty)

endmodule

@@ tb/c_subset_lexer_unit_tb.sv @@
`timescale 1ns / 100ps

module c_subset_lexer_unit_tb;
    import csl_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE_CYCLES = 20;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_CR  = 8'h0D;

    typedef enum logic [2:0] {
        SCAN_IDLE,
        SCAN_SLASH,
        SCAN_LINE,
        SCAN_BLOCK,
        SCAN_BSTAR,
        SCAN_IDENT,
        SCAN_NUMBER,
        SCAN_ASSIGN
    } scan_mode_e;

    typedef struct packed {
        logic     hold_for_drain;
        csl_src_t item;
    } src_entry_t;

    logic     clk;
    logic     rst_n = 1'b0;
    logic     src_valid = 1'b0;
    logic     src_stall;
    csl_src_t src_item = '0;
    logic     tok_valid;
    logic     tok_stall = 1'b0;
    csl_res_t tok_item;

    src_entry_t source_bytes [$];
    csl_res_t   expected_tokens [$];
    src_entry_t next_src;
    csl_res_t   want_tok;
    bit         hold_next = 1'b0;
    logic       src_fire = 1'b0;
    int         src_gap = 0;
    int         src_calm = 0;
    int         sink_hold = 0;
    int         sink_calm = 0;
    int         cycle_count = 0;
    int         fail_count = 0;

    scan_mode_e          mode = SCAN_IDLE;
    logic [LEN_W-1:0]    run_len = '0;
    logic [3:0]          kw_live = '0;
    logic                has_dot = 1'b0;
    logic [TOTAL_W-1:0]  tally = '0;
    csl_res_t            byte_tokens [2];
    int                  byte_token_count;

    c_subset_lexer_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_item  (src_item),
        .tok_valid (tok_valid),
        .tok_stall (tok_stall),
        .tok_item  (tok_item)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic string kw_text(input int k);
        string s;
        case (k)
            0: s = "int";
            1: s = "if";
            2: s = "else";
            default: s = "while";
        endcase
        return s;
    endfunction

    function automatic bit is_blank(input logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic bit is_letter(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic bit is_num(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic int draw_pause();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] ident_char(input bit lead);
        int r;
        r = $urandom_range(0, lead ? 52 : 62);
        if (r < 26)
            return 8'("a" + r);
        if (r < 52)
            return 8'("A" + r - 26);
        if (r == 52)
            return CH_UNDER;
        return 8'("0" + r - 53);
    endfunction

    function automatic logic [7:0] blank_char();
        int r;
        r = $urandom_range(8, 13);
        return (r == 8) ? CH_SPACE : 8'(r);
    endfunction

    task automatic count_token(input logic [KIND_W-1:0] kind, input logic [LEN_W-1:0] len,
                               input logic [KWI_W-1:0] kwi);
        csl_res_t t;
        t = '0;
        t.token_kind = kind;
        t.token_length = len;
        t.keyword_index = kwi;
        if (tally != '1)
            tally++;
        byte_tokens[byte_token_count] = t;
        byte_token_count++;
    endtask

    task automatic close_token();
        int                k;
        string             w;
        logic [KIND_W-1:0] kind;
        logic [KWI_W-1:0]  kwi;
        kind = K_IDENT;
        kwi = '0;
        case (mode)
            SCAN_IDENT:
            begin
                for (k = 0; k < 4; k++)
                begin
                    w = kw_text(k);
                    if (kw_live[k] && w.len() == run_len)
                    begin
                        kind = K_KEYWORD;
                        kwi = 2'(k);
                    end
                end
                count_token(kind, run_len, kwi);
            end
            SCAN_NUMBER: count_token(has_dot ? K_FLOAT : K_INT, run_len, '0);
            SCAN_ASSIGN: count_token(K_ASSIGN, 8'd1, '0);
            default: ;
        endcase
        mode = SCAN_IDLE;
    endtask

    task automatic start_byte(input logic [7:0] c);
        int    k;
        string w;
        mode = SCAN_IDLE;
        if (is_blank(c))
            ;
        else if (c == CH_SLASH)
            mode = SCAN_SLASH;
        else if (is_letter(c) || c == CH_UNDER)
        begin
            mode = SCAN_IDENT;
            run_len = 8'd1;
            kw_live = '0;
            for (k = 0; k < 4; k++)
            begin
                w = kw_text(k);
                if (w[0] == c)
                    kw_live[k] = 1'b1;
            end
        end
        else if (is_num(c))
        begin
            mode = SCAN_NUMBER;
            run_len = 8'd1;
            has_dot = 1'b0;
        end
        else if (c == CH_PLUS)
            count_token(K_PLUS, 8'd1, '0);
        else if (c == CH_MINUS)
            count_token(K_MINUS, 8'd1, '0);
        else if (c == CH_STAR)
            count_token(K_STAR, 8'd1, '0);
        else if (c == CH_EQ)
            mode = SCAN_ASSIGN;
    endtask

    task automatic lex_source_byte(input csl_src_t it);
        logic [7:0] c;
        int         k;
        string      w;
        csl_res_t   t;
        int         i;
        c = it.ch;
        byte_token_count = 0;
        if (it.end_of_text)
        begin
            close_token();
            t = '0;
            t.token_kind = K_TOTAL;
            t.token_total = tally;
            byte_tokens[byte_token_count] = t;
            byte_token_count++;
            mode = SCAN_IDLE;
            run_len = '0;
            kw_live = '0;
            has_dot = 1'b0;
            tally = '0;
        end
        else
        begin
            case (mode)
                SCAN_LINE:
                    if (c == CH_LF)
                        mode = SCAN_IDLE;
                SCAN_BLOCK:
                    if (c == CH_STAR)
                        mode = SCAN_BSTAR;
                SCAN_BSTAR:
                    if (c == CH_SLASH)
                        mode = SCAN_IDLE;
                    else if (c != CH_STAR)
                        mode = SCAN_BLOCK;
                SCAN_SLASH:
                    if (c == CH_SLASH)
                        mode = SCAN_LINE;
                    else if (c == CH_STAR)
                        mode = SCAN_BLOCK;
                    else
                        start_byte(c);
                SCAN_IDENT:
                    if (is_letter(c) || is_num(c) || c == CH_UNDER)
                    begin
                        for (k = 0; k < 4; k++)
                        begin
                            w = kw_text(k);
                            if (!(run_len < w.len() && w[run_len] == c))
                                kw_live[k] = 1'b0;
                        end
                        if (run_len != '1)
                            run_len++;
                    end
                    else
                    begin
                        close_token();
                        start_byte(c);
                    end
                SCAN_NUMBER:
                    if (is_num(c) || c == CH_DOT)
                    begin
                        if (c == CH_DOT)
                            has_dot = 1'b1;
                        if (run_len != '1)
                            run_len++;
                    end
                    else
                    begin
                        close_token();
                        start_byte(c);
                    end
                SCAN_ASSIGN:
                    if (c == CH_EQ)
                    begin
                        count_token(K_EQUAL, 8'd2, '0);
                        mode = SCAN_IDLE;
                    end
                    else
                    begin
                        close_token();
                        start_byte(c);
                    end
                default: start_byte(c);
            endcase
        end
        for (i = 0; i < byte_token_count; i++)
        begin
            t = byte_tokens[i];
            t.last_of_run = (i == byte_token_count - 1);
            expected_tokens.push_back(t);
        end
    endtask

    task automatic push_byte(input logic [7:0] b);
        src_entry_t e;
        e.hold_for_drain = hold_next;
        e.item.ch = b;
        e.item.end_of_text = 1'b0;
        source_bytes.push_back(e);
        hold_next = 1'b0;
    endtask

    task automatic push_str(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            push_byte(s[i]);
    endtask

    task automatic push_eot();
        src_entry_t e;
        e.hold_for_drain = hold_next;
        e.item.ch = 8'($urandom_range(0, 255));
        e.item.end_of_text = 1'b1;
        source_bytes.push_back(e);
        hold_next = 1'b0;
    endtask

    // sample both channels and check results
    always @(posedge clk)
    begin
        if (!rst_n)
            src_fire <= 1'b0;
        else if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
        else
        begin
            cycle_count++;
            src_fire <= src_valid && !src_stall;
            if (src_valid && !src_stall)
                lex_source_byte(src_item);
            if (tok_valid && !tok_stall)
            begin
                if (expected_tokens.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected token: kind %0d len %0d kwi %0d total %0d last %0d",
                                 tok_item.token_kind, tok_item.token_length,
                                 tok_item.keyword_index, tok_item.token_total,
                                 tok_item.last_of_run);
                end
                else
                begin
                    want_tok = expected_tokens.pop_front();
                    if (tok_item !== want_tok)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"token mismatch (expected/actual): kind %0d/%0d ",
                                      "len %0d/%0d kwi %0d/%0d total %0d/%0d last %0d/%0d"},
                                     want_tok.token_kind, tok_item.token_kind,
                                     want_tok.token_length, tok_item.token_length,
                                     want_tok.keyword_index, tok_item.keyword_index,
                                     want_tok.token_total, tok_item.token_total,
                                     want_tok.last_of_run, tok_item.last_of_run);
                    end
                end
            end
        end
    end

    // source driver: hold until transfer, then gap or advance
    always @(negedge clk)
    begin
        if (rst_n && (!src_valid || src_fire))
        begin
            if (src_gap > 0)
            begin
                src_valid <= 1'b0;
                src_gap--;
            end
            else if (source_bytes.size() > 0 &&
                     !(source_bytes[0].hold_for_drain && expected_tokens.size() > 0))
            begin
                next_src = source_bytes.pop_front();
                src_item <= next_src.item;
                src_valid <= 1'b1;
                if (src_calm > 0)
                begin
                    src_calm--;
                    src_gap = 0;
                end
                else if ($urandom_range(0, 99) == 0)
                begin
                    src_calm = $urandom_range(40, 120);
                    src_gap = 0;
                end
                else
                    src_gap = draw_pause();
            end
            else
                src_valid <= 1'b0;
        end
    end

    // result sink stall
    always @(negedge clk)
    begin
        if (sink_hold > 0)
        begin
            tok_stall <= 1'b1;
            sink_hold--;
        end
        else
        begin
            tok_stall <= 1'b0;
            if (sink_calm > 0)
                sink_calm--;
            else if ($urandom_range(0, 199) == 0)
                sink_calm = $urandom_range(50, 200);
            else if ($urandom_range(0, 3) == 0)
                sink_hold = draw_pause();
        end
    end

    initial
    begin
        int    text_idx;
        int    n_tok;
        int    j;
        int    pick;
        string w;

        push_str("while=else==if*9.");
        push_eot();
        push_str("in+");
        push_byte(8'hFF);
        push_byte(8'h00);
        push_byte(CH_EQ);
        push_eot();
        push_str("/*");
        push_eot();

        text_idx = 0;
        while (source_bytes.size() < 800)
        begin
            text_idx++;
            hold_next = (text_idx % 5 == 1);
            if (text_idx == 3)
            begin
                push_byte("w");
                repeat ($urandom_range(258, 266))
                    push_byte(ident_char(1'b0));
                push_byte(blank_char());
            end
            if (text_idx == 6)
            begin
                push_byte("7");
                repeat ($urandom_range(256, 260))
                    push_byte(($urandom_range(0, 9) == 0) ? CH_DOT
                              : 8'("0" + $urandom_range(0, 9)));
                push_byte(blank_char());
            end
            n_tok = $urandom_range(1, 12);
            for (j = 0; j < n_tok; j++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 14)
                    push_str(kw_text($urandom_range(0, 3)));
                else if (pick < 22)
                begin
                    w = kw_text($urandom_range(0, 3));
                    if ($urandom_range(0, 1))
                        push_str(w.substr(0, w.len() - 2));
                    else
                    begin
                        push_str(w);
                        push_byte(ident_char(1'b0));
                    end
                end
                else if (pick < 36)
                begin
                    push_byte(ident_char(1'b1));
                    repeat ($urandom_range(0, 7))
                        push_byte(ident_char(1'b0));
                end
                else if (pick < 50)
                begin
                    push_byte(8'("0" + $urandom_range(0, 9)));
                    repeat ($urandom_range(0, 5))
                        push_byte(($urandom_range(0, 3) == 0) ? CH_DOT
                                  : 8'("0" + $urandom_range(0, 9)));
                end
                else if (pick < 66)
                begin
                    case ($urandom_range(0, 4))
                        0: push_byte(CH_PLUS);
                        1: push_byte(CH_MINUS);
                        2: push_byte(CH_STAR);
                        3: push_byte(CH_EQ);
                        default: push_str("==");
                    endcase
                end
                else if (pick < 74)
                begin
                    push_str("//");
                    repeat ($urandom_range(0, 6))
                        push_byte(8'($urandom_range(0, 255)));
                    if ($urandom_range(0, 9) != 0)
                        push_byte(CH_LF);
                end
                else if (pick < 82)
                begin
                    push_str("/*");
                    repeat ($urandom_range(0, 6))
                    begin
                        case ($urandom_range(0, 2))
                            0: push_byte(CH_STAR);
                            1: push_byte(CH_SLASH);
                            default: push_byte(8'($urandom_range(0, 255)));
                        endcase
                    end
                    if ($urandom_range(0, 19) != 0)
                        push_str(($urandom_range(0, 1) == 0) ? "*/" : "**/");
                end
                else if (pick < 86)
                    push_byte(CH_SLASH);
                else
                    push_byte(8'($urandom_range(0, 255)));
                if ($urandom_range(0, 9) < 6)
                    push_byte(blank_char());
            end
            push_eot();
        end

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (source_bytes.size() != 0 || (src_valid && !src_fire))
            @(negedge clk);
        @(negedge clk);
        while (expected_tokens.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);

        if (fail_count == 0 && expected_tokens.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
